// File: hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

	localparam int COLOR_W   = 8;
	localparam int HUE_W     = 9;
	localparam int PCT_W     = 7;
	// hue numerator stays below 360 * 255
	localparam int HNUM_W    = 17;
	// saturation numerator is at most 100 * 255
	localparam int SNUM_W    = 15;
	// one quotient bit per divider stage
	localparam int DIV_STAGES = HUE_W;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// item state while it walks the divider stages
	typedef struct packed {
		logic [HNUM_W-1:0]  hnum;
		logic [COLOR_W-1:0] hden;
		logic [SNUM_W-1:0]  snum;
		logic [COLOR_W-1:0] sden;
		logic [HUE_W-1:0]   hq;
		logic [PCT_W-1:0]   sq;
		logic [PCT_W-1:0]   val;
	} div_stage_t;

endpackage

// File: hdl/rgbhsv_div_pipe.sv
module rgbhsv_div_pipe
	import rgbhsv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  div_stage_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output div_stage_t out_data
);

	div_stage_t               pipe_s [1:DIV_STAGES];
	logic [DIV_STAGES:1]      valid_s;
	logic [DIV_STAGES:1]      adv;

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		localparam int BIT = DIV_STAGES - k;

		div_stage_t src;
		logic       src_valid;
		div_stage_t nxt;
		logic [HNUM_W-1:0] hden_sh;
		logic [SNUM_W-1:0] sden_sh;

		// pick the upstream register
		if (k == 1) begin : g_first
			assign src       = in_data;
			assign src_valid = in_valid;
		end else begin : g_mid
			assign src       = pipe_s[k-1];
			assign src_valid = valid_s[k-1];
		end

		// advance when empty or when the next stage moves
		if (k == DIV_STAGES) begin : g_last
			assign adv[k] = !valid_s[k] || out_ready;
		end else begin : g_chain
			assign adv[k] = !valid_s[k] || adv[k+1];
		end

		assign hden_sh = HNUM_W'(src.hden) << BIT;
		assign sden_sh = SNUM_W'(src.sden) << BIT;

		// one restoring step for hue, and for saturation on its low bits
		always_comb begin
			nxt = src;
			if (src.hnum >= hden_sh) begin
				nxt.hnum    = src.hnum - hden_sh;
				nxt.hq[BIT] = 1'b1;
			end
			if (BIT < PCT_W) begin
				if (src.snum >= sden_sh) begin
					nxt.snum = src.snum - sden_sh;
					nxt.sq[BIT % PCT_W] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv[k]) begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && src_valid) begin
				pipe_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = valid_s[DIV_STAGES];
	assign out_data  = pipe_s[DIV_STAGES];

	// remainders end below their divisors
	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DIV_STAGES] |-> (pipe_s[DIV_STAGES].hnum < HNUM_W'(pipe_s[DIV_STAGES].hden))
			&& (pipe_s[DIV_STAGES].snum < SNUM_W'(pipe_s[DIV_STAGES].sden)))
		else $error("divider remainder not reduced");

	// saturation quotient fits in its skipped-top-bit range on entry
	a_sat_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && adv[1]) |->
			(in_data.snum < (SNUM_W'(in_data.sden) << PCT_W)))
		else $error("saturation quotient overflows");

	// hold a blocked output item steady
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("blocked output item changed");

endmodule

// File: hdl/rgb_to_hsv_converter.sv
// RGB to HSV converter. Takes one 8-bit red/green/blue item per clock while
// not stalled and returns hue in whole degrees (0-359) plus saturation and
// brightness in percent (0-100), all rounded down; black and gray inputs give
// hue 0 and saturation 0. The pipeline accepts a new item every cycle unless
// stalled and has eleven register stages: one stage finds max, min and the
// sector, one forms the numerators and brightness, and nine restoring divider
// stages resolve one quotient bit each. The first stage loads at the accepting
// edge, and out_valid rises once the item reaches the last divider stage.
// Backpressure on out_ready stalls only stages that are full, so bubbles are
// squeezed out.
module rgb_to_hsv_converter
	import rgbhsv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [HUE_W-1:0]   hue,
	output logic [PCT_W-1:0]   saturation,
	output logic [PCT_W-1:0]   brightness
);

	logic                       valid_s1;
	logic [COLOR_W-1:0]         mx_s1;
	logic [COLOR_W-1:0]         d_s1;
	logic signed [COLOR_W:0]    diff_s1;
	sector_t                    sect_s1;

	logic                       valid_s2;
	div_stage_t                 data_s2;

	logic                       en_s1;
	logic                       en_s2;
	logic                       div_ready;
	div_stage_t                 div_out;

	logic [COLOR_W-1:0]         mx;
	logic [COLOR_W-1:0]         mn;
	sector_t                    sect;
	logic signed [COLOR_W:0]    diff;

	localparam int ACC_W = HNUM_W + 2;
	logic signed [ACC_W-1:0]    d_x;
	logic signed [ACC_W-1:0]    diff_x;
	logic signed [ACC_W-1:0]    base;
	logic signed [ACC_W-1:0]    hacc;
	logic [SNUM_W-1:0]          vscaled;
	logic [SNUM_W-1:0]          vsum;
	div_stage_t                 nxt_s2;

	// stall chain, back from the divider
	assign en_s2    = !valid_s2 || div_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// find max, min and the sector of the largest component
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sect = SECT_RED;
			diff = signed'({1'b0, green}) - signed'({1'b0, blue});
		end else if (mx == green) begin
			sect = SECT_GREEN;
			diff = signed'({1'b0, blue}) - signed'({1'b0, red});
		end else begin
			sect = SECT_BLUE;
			diff = signed'({1'b0, red}) - signed'({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mx_s1   <= mx;
			d_s1    <= mx - mn;
			diff_s1 <= diff;
			sect_s1 <= sect;
		end
	end

	// form numerators and brightness; force a zero divide to 0/1
	always_comb begin
		d_x    = signed'({{(ACC_W-COLOR_W){1'b0}}, d_s1});
		diff_x = ACC_W'(diff_s1);
		case (sect_s1)
			SECT_RED:   base = (diff_s1 < 0) ? d_x * ACC_W'(360) : '0;
			SECT_GREEN: base = d_x * ACC_W'(120);
			SECT_BLUE:  base = d_x * ACC_W'(240);
			default:    base = '0;
		endcase
		hacc = base + diff_x * ACC_W'(60);

		// x / 255 as (x + (x >> 8) + 1) >> 8, exact for x below 65535
		vscaled = SNUM_W'(mx_s1) * SNUM_W'(100);
		vsum    = vscaled + (vscaled >> 8) + SNUM_W'(1);

		nxt_s2.hq  = '0;
		nxt_s2.sq  = '0;
		nxt_s2.val = vsum[8 +: PCT_W];
		if (d_s1 == '0) begin
			nxt_s2.hnum = '0;
			nxt_s2.hden = COLOR_W'(1);
			nxt_s2.snum = '0;
			nxt_s2.sden = COLOR_W'(1);
		end else begin
			nxt_s2.hnum = hacc[HNUM_W-1:0];
			nxt_s2.hden = d_s1;
			nxt_s2.snum = SNUM_W'(d_s1) * SNUM_W'(100);
			nxt_s2.sden = mx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			data_s2 <= nxt_s2;
		end
	end

	rgbhsv_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (div_ready),
		.in_data   (data_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (div_out)
	);

	assign hue        = div_out.hq;
	assign saturation = div_out.sq;
	assign brightness = div_out.val;

	// hue stays below a full turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue < HUE_W'(360)))
		else $error("hue out of range");

	// percentages stay at or below 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (saturation <= PCT_W'(100)) && (brightness <= PCT_W'(100)))
		else $error("percentage out of range");

	// input stalls only when the output is holding an item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("stall without a blocked output");

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsv_pkg::*;

	localparam int RANDOM_PIXELS = 1330;
	localparam int MAX_WAIT      = 13;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_AT       = 300;
	localparam int PAUSE_AT      = 700;

	// one converted pixel, with the sample that produced it
	typedef struct {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [HUE_W-1:0]   hue;
		logic [PCT_W-1:0]   saturation;
		logic [PCT_W-1:0]   brightness;
	} hsv_pixel_t;

	// predict each accepted sample and compare results in order
	class hsv_scoreboard;
		hsv_pixel_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function hsv_pixel_t predict_hsv(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
				logic [COLOR_W-1:0] b);
			hsv_pixel_t px;
			int ri, gi, bi, mx, mn, span, num;
			ri = r;
			gi = g;
			bi = b;
			mx = ri;
			mn = ri;
			if (gi > mx) mx = gi;
			if (bi > mx) mx = bi;
			if (gi < mn) mn = gi;
			if (bi < mn) mn = bi;
			span = mx - mn;
			px.red = r;
			px.green = g;
			px.blue = b;
			px.brightness = PCT_W'((100 * mx) / 255);
			px.saturation = '0;
			px.hue = '0;
			// black and gray keep hue and saturation at zero
			if (mx != 0) begin
				px.saturation = PCT_W'((100 * span) / mx);
				if (span != 0) begin
					// red wins ties, then green
					if (mx == ri) begin
						num = 60 * (gi - bi);
						if (num < 0) num += 360 * span;
					end else if (mx == gi) begin
						num = 120 * span + 60 * (bi - ri);
					end else begin
						num = 240 * span + 60 * (ri - gi);
					end
					px.hue = HUE_W'(num / span);
				end
			end
			return px;
		endfunction

		function void note_sample(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
				logic [COLOR_W-1:0] b);
			expected_q.push_back(predict_hsv(r, g, b));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [HUE_W-1:0] h, logic [PCT_W-1:0] s, logic [PCT_W-1:0] v);
			hsv_pixel_t px;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result hue=%0d sat=%0d val=%0d", h, s, v));
				return;
			end
			px = expected_q.pop_front();
			if (h !== px.hue)
				report($sformatf("rgb=%0d,%0d,%0d hue %0d, want %0d",
					px.red, px.green, px.blue, h, px.hue));
			if (s !== px.saturation)
				report($sformatf("rgb=%0d,%0d,%0d saturation %0d, want %0d",
					px.red, px.green, px.blue, s, px.saturation));
			if (v !== px.brightness)
				report($sformatf("rgb=%0d,%0d,%0d brightness %0d, want %0d",
					px.red, px.green, px.blue, v, px.brightness));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               out_valid;
	logic               out_ready;
	logic [HUE_W-1:0]   hue;
	logic [PCT_W-1:0]   saturation;
	logic [PCT_W-1:0]   brightness;

	hsv_scoreboard sb = new();
	bit hold_req = 1'b0;
	int send_burst = 0;
	int recv_burst = 0;

	rgb_to_hsv_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// note accepted samples, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_sample(red, green, blue);
			if (out_valid && out_ready) sb.check_result(hue, saturation, brightness);
		end
	end

	// offer one sample after a random gap and hold it until accepted
	task automatic send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		int gap;
		if (send_burst > 0) begin
			send_burst--;
			gap = 0;
		end else begin
			gap = $urandom_range(MAX_WAIT, 0);
			if ($urandom_range(39, 0) == 0) send_burst = $urandom_range(60, 20);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// lower valid and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// result side: random stalls, bursts of full rate, one long hold-off
	initial begin : result_sink
		int wait_cycles;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				wait_cycles = LONG_HOLD;
			end else if (recv_burst > 0) begin
				recv_burst--;
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(MAX_WAIT, 0);
				if ($urandom_range(39, 0) == 0) recv_burst = $urandom_range(60, 20);
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		logic [3*COLOR_W-1:0] corners [$];
		logic [COLOR_W-1:0] r, g, b, top, low;
		corners = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
			24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
			24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hC80A64,
			24'hFFFF0A, 24'h0AFFFF, 24'h010000, 24'h000100,
			24'h000001, 24'hFE01FD, 24'hFFFEFD, 24'h030201,
			24'hAA55AA, 24'h55AA55, 24'h7F80FF, 24'h01FF00
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, gray, primaries, ties and negative red-sector hue
		foreach (corners[i])
			send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			if (n == HOLD_AT) hold_req = 1'b1;
			if (n == PAUSE_AT) drain_results();
			case ($urandom_range(9, 0))
				0: begin
					r = $urandom_range(255, 0);
					g = r;
					b = r;
				end
				1: begin
					top = $urandom_range(255, 1);
					low = $urandom_range(top, 0);
					case ($urandom_range(2, 0))
						0: {r, g, b} = {top, top, low};
						1: {r, g, b} = {top, low, top};
						default: {r, g, b} = {low, top, top};
					endcase
				end
				2: begin
					r = $urandom_range(3, 0);
					g = $urandom_range(3, 0);
					b = $urandom_range(3, 0);
				end
				default: begin
					r = $urandom_range(255, 0);
					g = $urandom_range(255, 0);
					b = $urandom_range(255, 0);
				end
			endcase
			send_pixel(r, g, b);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// abort a hung run
	initial begin
		#3_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
